### sv/pen_tip_filter_and_gate_defines.svh
// assertion macros for the pen tip filter and gate
`ifndef PEN_TIP_FILTER_AND_GATE_DEFINES_SVH
`define PEN_TIP_FILTER_AND_GATE_DEFINES_SVH

`ifndef SYNTH
`define PTF_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PTF_ASSERT_NR(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTF_ASSERT(name, prop, msg)
`define PTF_ASSERT_NR(name, prop, msg)
`endif

`endif

### sv/ptf_pkg.sv
package ptf_pkg;

	localparam int HISTORY_TAPS_DEF = 5;

	localparam int DEG90    = 5760;
	localparam int DEG180   = 11520;
	localparam int DEG360   = 23040;
	localparam int MIRROR_X = 11648;
	localparam int MIRROR_Y = 15488;
	localparam int Z_NEAR   = 3200;
	localparam int Z_FAR    = 12800;
	localparam int H_DEN    = Z_FAR - Z_NEAR;

	localparam int CORDIC_STEPS = 16;
	localparam int CRD_W        = 33;
	localparam int ANG_W        = 24;
	localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 33'sd652032875;

	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DIV_NW = 40;
	localparam int DIV_DW = 20;

	localparam int WIN_MAX = 262143;
	localparam int WIN_MIN = -262144;

	localparam logic [2:0] REG_SIDE   = 3'd0;
	localparam logic [2:0] REG_STICK  = 3'd1;
	localparam logic [2:0] REG_WWIDTH = 3'd2;
	localparam logic [2:0] REG_WHEIGHT= 3'd3;
	localparam logic [2:0] REG_THRESH = 3'd4;
	localparam logic [2:0] REG_YLOW   = 3'd5;
	localparam logic [2:0] REG_YHIGH  = 3'd6;

	typedef enum logic {OP_MUL, OP_DIV} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_ctl_t;

	typedef enum logic [4:0] {
		S_IDLE, S_HGO, S_HWAIT, S_CGO, S_CWAIT, S_DGO, S_DWAIT, S_TGO, S_TWAIT,
		S_SUM, S_AGO, S_AWAIT, S_DIST, S_GATE, S_WXGO, S_WXWAIT, S_WXDGO,
		S_WXDWAIT, S_WYGO, S_WYWAIT, S_WYDGO, S_WYDWAIT, S_PUT
	} state_t;

	function automatic logic [ANG_W-1:0] arc_step(input logic [3:0] i);
		logic [ANG_W-1:0] r;
		case (i)
			4'd0:  r = 24'd737280;
			4'd1:  r = 24'd435242;
			4'd2:  r = 24'd229970;
			4'd3:  r = 24'd116736;
			4'd4:  r = 24'd58595;
			4'd5:  r = 24'd29326;
			4'd6:  r = 24'd14667;
			4'd7:  r = 24'd7334;
			4'd8:  r = 24'd3667;
			4'd9:  r = 24'd1833;
			4'd10: r = 24'd917;
			4'd11: r = 24'd458;
			4'd12: r = 24'd229;
			4'd13: r = 24'd115;
			4'd14: r = 24'd57;
			4'd15: r = 24'd29;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [DIV_NW:0] v);
		logic signed [15:0] r;
		if (v > 41'sd32767)
			r = 16'sh7FFF;
		else if (v < -41'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [18:0] sat19(input logic signed [DIV_NW:0] v);
		logic signed [18:0] r;
		if (v > 41'(WIN_MAX))
			r = 19'(WIN_MAX);
		else if (v < 41'(WIN_MIN))
			r = 19'(WIN_MIN);
		else
			r = v[18:0];
		return r;
	endfunction

endpackage

### sv/ptf_arith.sv
module ptf_arith import ptf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  arith_ctl_t               ctl,
	input  logic signed [MUL_W-1:0]  mul_a,
	input  logic signed [MUL_W-1:0]  mul_b,
	input  logic signed [DIV_NW:0]   div_a,
	input  logic [DIV_DW-1:0]        div_b,
	output logic                     done,
	output logic signed [PROD_W-1:0] prod,
	output logic signed [DIV_NW:0]   quo
);
	localparam int CNT_W = $clog2(DIV_NW);

	logic                     busy_q, done_q, neg_q;
	arith_op_t                op_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [PROD_W-1:0] acc_q, mcand_q;
	logic [MUL_W-1:0]         mplier_q;
	logic [DIV_DW-1:0]        rem_q, dvs_q;
	logic [DIV_NW-1:0]        quo_q;
	logic [DIV_NW:0]          mag;
	logic [DIV_DW:0]          shifted;
	logic [DIV_DW+1:0]        trial;

	always_comb begin
		if (div_a[DIV_NW])
			mag = (-div_a) + (DIV_NW+1)'(div_b) - 1'b1;
		else
			mag = div_a;
		shifted = {rem_q, quo_q[DIV_NW-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if ((op_q == OP_MUL && cnt_q == CNT_W'(MUL_W-1)) ||
				    (op_q == OP_DIV && cnt_q == CNT_W'(DIV_NW-1))) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add multiply, restoring divide, one bit per cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q    <= '0;
			mcand_q  <= PROD_W'(mul_a);
			mplier_q <= mul_b;
			neg_q    <= div_a[DIV_NW];
			quo_q    <= mag[DIV_NW-1:0];
			rem_q    <= '0;
			dvs_q    <= div_b;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				if (mplier_q[0]) begin
					if (cnt_q == CNT_W'(MUL_W-1))
						acc_q <= acc_q - mcand_q;
					else
						acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
			end else begin
				if (!trial[DIV_DW+1]) begin
					rem_q <= trial[DIV_DW-1:0];
					quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
				end else begin
					rem_q <= shifted[DIV_DW-1:0];
					quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign quo  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

### sv/ptf_cordic.sv
module ptf_cordic import ptf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [15:0]      angle,
	output logic                    done,
	output logic signed [CRD_W-1:0] sin_v,
	output logic signed [CRD_W-1:0] cos_v
);
	logic                    busy_q, done_q, flip_q, flip0;
	logic [3:0]              i_q;
	logic signed [CRD_W-1:0] x_q, y_q, sin_q, cos_q, nx, ny, xs, ys;
	logic signed [ANG_W-1:0] z_q, nz, z0;
	logic signed [16:0]      a0, a1, a2;

	always_comb begin
		a0 = 17'(angle);
		if (a0 > 17'(DEG180))
			a1 = a0 - 17'(DEG360);
		else if (a0 <= -17'(DEG180))
			a1 = a0 + 17'(DEG360);
		else
			a1 = a0;
		// fold into the right half plane
		flip0 = 1'b0;
		a2    = a1;
		if (a1 > 17'(DEG90)) begin
			a2    = a1 - 17'(DEG180);
			flip0 = 1'b1;
		end else if (a1 < -17'(DEG90)) begin
			a2    = a1 + 17'(DEG180);
			flip0 = 1'b1;
		end
		z0 = ANG_W'(a2) <<< 8;
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		if (!z_q[ANG_W-1]) begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - $signed(arc_step(i_q));
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + $signed(arc_step(i_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 4'(CORDIC_STEPS-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= z0;
			flip_q <= flip0;
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
			if (i_q == 4'(CORDIC_STEPS-1)) begin
				sin_q <= flip_q ? -ny : ny;
				cos_q <= flip_q ? -nx : nx;
			end
		end
	end

	assign done  = done_q;
	assign sin_v = sin_q;
	assign cos_v = cos_q;

endmodule

### sv/pen_tip_filter_and_gate.sv
// channel  | valid / ready               | payload
// sample   | sample_valid / sample_ready | pos_x pos_y pos_z tilt_x tilt_y
// result   | result_valid / result_ready | kind window_x window_y height
// config   | psel penable pwrite pready  | paddr pwdata prdata
//
// one item at a time; a height is computed by the 40-step divider
// a pen point runs two 16-step cordic passes, then seven multiplies
// and up to five divides on one shared shift-add unit
// a rejected pen point is dropped at the gate check and gives no result
// the finished item waits in the output register while the next one is taken
// reset clears control, configuration, history and last emitted tip at once
module pen_tip_filter_and_gate import ptf_pkg::*; #(
	parameter int HISTORY_TAPS = HISTORY_TAPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic signed [14:0] tilt_x,
	input  logic signed [14:0] tilt_y,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               kind,
	output logic signed [18:0] window_x,
	output logic signed [18:0] window_y,
	output logic [15:0]        height
);
`include "pen_tip_filter_and_gate_defines.svh"

	localparam int IDX_W  = (HISTORY_TAPS > 1) ? $clog2(HISTORY_TAPS) : 1;
	localparam int LAST_I = (HISTORY_TAPS > 2) ? HISTORY_TAPS - 2 : 0;
	localparam int SUM_W  = 17 + $clog2(HISTORY_TAPS);

	state_t state_q, state_d;

	logic        side_q;
	logic [13:0] stick_q;
	logic [12:0] ww_q, wh_q;
	logic [7:0]  thr_q;
	logic signed [15:0] ylow_q, yhigh_q;

	logic signed [15:0] px_q, py_q, pz_q;
	logic signed [14:0] tx_q, ty_q;
	logic signed [15:0] hist_q [HISTORY_TAPS][3];
	logic signed [15:0] last_q [3];
	logic signed [15:0] tip_q [3];
	logic signed [15:0] avg_q [3];
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [MUL_W-1:0] d_q [3];
	logic signed [CRD_W-1:0] sp_q, st_q, ct_q;
	logic signed [DIV_NW:0]  n_q;
	logic [35:0]        dist_q;
	logic [1:0]         k_q;
	logic [IDX_W-1:0]   i_q;

	logic               res_kind_q;
	logic signed [18:0] res_wx_q, res_wy_q;
	logic [15:0]        res_h_q;
	logic               out_valid_q, out_kind_q;
	logic signed [18:0] out_wx_q, out_wy_q;
	logic [15:0]        out_h_q;

	logic                     cfg_wr, accept, put;
	arith_ctl_t               actl;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [DIV_NW:0]   div_a;
	logic [DIV_DW-1:0]        div_b;
	logic                     arith_done;
	logic signed [PROD_W-1:0] prod, psh, rnd;
	logic signed [DIV_NW:0]   quo;
	logic                     cordic_start, cordic_done;
	logic signed [CRD_W-1:0]  sin_v, cos_v;

	logic signed [17:0] p_v [3];
	logic signed [16:0] ty_e, ry, theta_w, phi_w, negz, zc, den17, dmag, ydiff;
	logic signed [15:0] crd_angle;
	logic signed [DIV_NW:0] h_num, nn;
	logic signed [21:0] zl, l22;
	logic [17:0]        nine_l;
	logic signed [20:0] tsum;
	logic signed [16:0] diff;
	logic signed [33:0] sq;
	logic [15:0]        thr2;
	logic               dneg;

	ptf_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (actl),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.div_a  (div_a),
		.div_b  (div_b),
		.done   (arith_done),
		.prod   (prod),
		.quo    (quo)
	);

	ptf_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (crd_angle),
		.done   (cordic_done),
		.sin_v  (sin_v),
		.cos_v  (cos_v)
	);

	assign cfg_wr       = psel && penable && pwrite;
	assign pready       = 1'b1;
	assign sample_ready = (state_q == S_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign put          = (state_q == S_PUT) && (!out_valid_q || result_ready);

	always_comb begin
		case (paddr[4:2])
			REG_SIDE:    prdata = {31'b0, side_q};
			REG_STICK:   prdata = {18'b0, stick_q};
			REG_WWIDTH:  prdata = {19'b0, ww_q};
			REG_WHEIGHT: prdata = {19'b0, wh_q};
			REG_THRESH:  prdata = {24'b0, thr_q};
			REG_YLOW:    prdata = 32'(ylow_q);
			REG_YHIGH:   prdata = 32'(yhigh_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= 1'b0;
			stick_q <= 14'd6400;
			ww_q    <= 13'd1024;
			wh_q    <= 13'd768;
			thr_q   <= 8'd38;
			ylow_q  <= -16'sd3200;
			yhigh_q <= 16'sd16000;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_SIDE:    side_q  <= pwdata[0];
				REG_STICK:   stick_q <= pwdata[13:0];
				REG_WWIDTH:  ww_q    <= pwdata[12:0];
				REG_WHEIGHT: wh_q    <= pwdata[12:0];
				REG_THRESH:  thr_q   <= pwdata[7:0];
				REG_YLOW:    ylow_q  <= pwdata[15:0];
				REG_YHIGH:   yhigh_q <= pwdata[15:0];
				default:     ;
			endcase
		end
	end

	// operand preparation
	always_comb begin
		p_v[0]  = 18'(MIRROR_X) - 18'(px_q);
		p_v[1]  = 18'(MIRROR_Y) - 18'(py_q);
		p_v[2]  = 18'(pz_q);
		ty_e    = 17'(ty_q);
		ry      = (!ty_e[16]) ? ty_e - 17'(DEG180) : ty_e + 17'(DEG180);
		theta_w = (!ry[16]) ? 17'(DEG180) - ry : -17'(DEG180) - ry;
		phi_w   = 17'(DEG180) - 17'(tx_q);
		crd_angle = (k_q == 2'd0) ? phi_w[15:0] : theta_w[15:0];

		negz = -17'(pz_q);
		if (negz < 17'(Z_NEAR))
			zc = 17'(Z_NEAR);
		else if (negz > 17'(Z_FAR))
			zc = 17'(Z_FAR);
		else
			zc = negz;
		h_num = $signed({10'b0, 14'(zc - 17'(Z_NEAR)), 17'b0}) + 41'(H_DEN);

		den17 = 17'(yhigh_q) - 17'(ylow_q);
		dneg  = den17[16];
		dmag  = dneg ? -den17 : den17;
		nn    = dneg ? -n_q : n_q;
		ydiff = 17'(avg_q[1]) - 17'(ylow_q);
		l22   = 22'($signed({1'b0, stick_q}));
		zl    = (22'(avg_q[2]) <<< 3) + (22'(avg_q[2]) <<< 1) + (l22 <<< 3) + (l22 <<< 1) + l22;
		nine_l = {1'b0, stick_q, 3'b000} + 18'(stick_q);

		psh  = prod >>> 30;
		rnd  = (prod + (PROD_W'(1) <<< 29)) >>> 30;
		tsum = 21'(p_v[k_q]) + $signed(rnd[20:0]);
		diff = 17'(avg_q[k_q]) - 17'(last_q[k_q]);
		sq   = diff * diff;
		thr2 = thr_q * thr_q;

		mul_a = '0;
		mul_b = '0;
		div_a = '0;
		div_b = '0;
		case (state_q)
			S_HGO: begin
				div_a = h_num;
				div_b = DIV_DW'(2 * H_DEN);
			end
			S_DGO: begin
				mul_a = MUL_W'(sp_q);
				mul_b = (k_q == 2'd0) ? MUL_W'(ct_q) : MUL_W'(st_q);
			end
			S_TGO: begin
				mul_a = d_q[k_q];
				mul_b = MUL_W'($signed({1'b0, stick_q}));
			end
			S_AGO: begin
				div_a = (41'(sum_q[k_q]) <<< 1) + 41'(HISTORY_TAPS);
				div_b = DIV_DW'(2 * HISTORY_TAPS);
			end
			S_WXGO: begin
				mul_a = MUL_W'(ydiff);
				mul_b = MUL_W'($signed({1'b0, ww_q}));
			end
			S_WXDGO: begin
				div_a = (nn <<< 1) + 41'($signed({1'b0, dmag[15:0]}));
				div_b = DIV_DW'({dmag[15:0], 1'b0});
			end
			S_WYGO: begin
				mul_a = MUL_W'(zl);
				mul_b = MUL_W'($signed({1'b0, wh_q}));
			end
			S_WYDGO: begin
				div_a = (n_q <<< 1) + 41'($signed({1'b0, nine_l}));
				div_b = DIV_DW'({nine_l, 1'b0});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		actl         = '{start: 1'b0, op: OP_MUL};
		cordic_start = 1'b0;
		case (state_q)
			S_IDLE:
				if (sample_valid)
					state_d = side_q ? S_HGO : S_CGO;
			S_HGO: begin
				actl    = '{start: 1'b1, op: OP_DIV};
				state_d = S_HWAIT;
			end
			S_HWAIT:
				if (arith_done)
					state_d = S_PUT;
			S_CGO: begin
				cordic_start = 1'b1;
				state_d      = S_CWAIT;
			end
			S_CWAIT:
				if (cordic_done)
					state_d = (k_q == 2'd1) ? S_DGO : S_CGO;
			S_DGO: begin
				actl    = '{start: 1'b1, op: OP_MUL};
				state_d = S_DWAIT;
			end
			S_DWAIT:
				if (arith_done)
					state_d = (k_q == 2'd1) ? S_TGO : S_DGO;
			S_TGO: begin
				actl    = '{start: 1'b1, op: OP_MUL};
				state_d = S_TWAIT;
			end
			S_TWAIT:
				if (arith_done)
					state_d = (k_q == 2'd2) ? S_SUM : S_TGO;
			S_SUM:
				if (i_q == IDX_W'(LAST_I))
					state_d = S_AGO;
			S_AGO: begin
				actl    = '{start: 1'b1, op: OP_DIV};
				state_d = S_AWAIT;
			end
			S_AWAIT:
				if (arith_done)
					state_d = (k_q == 2'd2) ? S_DIST : S_AGO;
			S_DIST:
				if (k_q == 2'd2)
					state_d = S_GATE;
			S_GATE:
				state_d = (dist_q > 36'(thr2)) ? S_WXGO : S_IDLE;
			S_WXGO: begin
				actl    = '{start: 1'b1, op: OP_MUL};
				state_d = S_WXWAIT;
			end
			S_WXWAIT:
				if (arith_done)
					state_d = S_WXDGO;
			S_WXDGO:
				if (den17 == '0) begin
					state_d = S_WYGO;
				end else begin
					actl    = '{start: 1'b1, op: OP_DIV};
					state_d = S_WXDWAIT;
				end
			S_WXDWAIT:
				if (arith_done)
					state_d = S_WYGO;
			S_WYGO: begin
				actl    = '{start: 1'b1, op: OP_MUL};
				state_d = S_WYWAIT;
			end
			S_WYWAIT:
				if (arith_done)
					state_d = S_WYDGO;
			S_WYDGO:
				if (stick_q == '0) begin
					state_d = S_PUT;
				end else begin
					actl    = '{start: 1'b1, op: OP_DIV};
					state_d = S_WYDWAIT;
				end
			S_WYDWAIT:
				if (arith_done)
					state_d = S_PUT;
			S_PUT:
				if (!out_valid_q || result_ready)
					state_d = S_IDLE;
			default:
				state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			i_q    <= '0;
			last_q <= '{default: '0};
			for (int j = 0; j < HISTORY_TAPS; j++)
				hist_q[j] <= '{default: '0};
		end else begin
			if (accept) begin
				k_q <= '0;
				i_q <= '0;
			end
			if ((state_q == S_CWAIT && cordic_done) || (state_q == S_DWAIT && arith_done))
				k_q <= (k_q == 2'd1) ? 2'd0 : k_q + 2'd1;
			if ((state_q == S_TWAIT || state_q == S_AWAIT) && arith_done)
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			if (state_q == S_DIST)
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			if (state_q == S_SUM)
				i_q <= (i_q == IDX_W'(LAST_I)) ? '0 : i_q + 1'b1;
			if (state_q == S_GATE && dist_q > 36'(thr2)) begin
				hist_q[0] <= tip_q;
				for (int j = 1; j < HISTORY_TAPS; j++)
					hist_q[j] <= hist_q[j-1];
				last_q <= avg_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q       <= pos_x;
			py_q       <= pos_y;
			pz_q       <= pos_z;
			tx_q       <= tilt_x;
			ty_q       <= tilt_y;
			dist_q     <= '0;
			res_kind_q <= side_q;
			res_wx_q   <= '0;
			res_wy_q   <= '0;
			res_h_q    <= '0;
		end
		case (state_q)
			S_HWAIT:
				if (arith_done)
					res_h_q <= (quo > 41'sd65535) ? 16'hFFFF : quo[15:0];
			S_CWAIT:
				if (cordic_done) begin
					if (k_q == 2'd0) begin
						sp_q   <= sin_v;
						d_q[2] <= -MUL_W'(cos_v);
					end else begin
						st_q <= sin_v;
						ct_q <= cos_v;
					end
				end
			S_DWAIT:
				if (arith_done) begin
					if (k_q == 2'd0)
						d_q[0] <= -psh[MUL_W-1:0];
					else
						d_q[1] <= psh[MUL_W-1:0];
				end
			S_TWAIT:
				if (arith_done) begin
					tip_q[k_q] <= sat16(41'(tsum));
					sum_q[k_q] <= SUM_W'(sat16(41'(tsum)));
				end
			S_SUM:
				if (HISTORY_TAPS > 1) begin
					for (int c = 0; c < 3; c++)
						sum_q[c] <= sum_q[c] + SUM_W'(hist_q[i_q][c]);
				end
			S_AWAIT:
				if (arith_done)
					avg_q[k_q] <= sat16(quo);
			S_DIST:
				dist_q <= dist_q + 36'(sq);
			S_WXWAIT, S_WYWAIT:
				if (arith_done)
					n_q <= $signed({prod[DIV_NW-4:0], 4'b0000});
			S_WXDWAIT:
				if (arith_done)
					res_wx_q <= sat19(quo);
			S_WYDWAIT:
				if (arith_done)
					res_wy_q <= sat19(quo);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (put)
			out_valid_q <= 1'b1;
		else if (result_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (put) begin
			out_kind_q <= res_kind_q;
			out_wx_q   <= res_wx_q;
			out_wy_q   <= res_wy_q;
			out_h_q    <= res_h_q;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = out_kind_q;
	assign window_x     = out_wx_q;
	assign window_y     = out_wy_q;
	assign height       = out_h_q;

	`PTF_ASSERT(a_height_item, result_valid && kind |-> window_x == '0 && window_y == '0, "height item with window coordinates")
	`PTF_ASSERT(a_point_item, result_valid && !kind |-> height == '0, "pen point with height")
	`PTF_ASSERT(a_cordic_done, cordic_done |-> state_q == S_CWAIT, "cordic finished unexpectedly")
	`PTF_ASSERT(a_arith_done, arith_done |-> state_q == S_HWAIT || state_q == S_DWAIT || state_q == S_TWAIT || state_q == S_AWAIT || state_q == S_WXWAIT || state_q == S_WXDWAIT || state_q == S_WYWAIT || state_q == S_WYDWAIT, "arith unit finished unexpectedly")
	`PTF_ASSERT(a_one_item, sample_valid && sample_ready |=> !sample_ready, "second item taken while busy")
	`PTF_ASSERT_NR(a_reset_quiet, !arst_n |=> !result_valid, "result shown during reset")

endmodule
